// ----- rtl/core/csfw_pkg.sv -----
package csfw_pkg;

    // queue geometry and field widths
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CMD_W       = 2;
    localparam int KIND_W      = 2;
    localparam int OUT_ID_W    = 8;
    localparam int CNT_W       = 16;

    typedef logic [PTR_W-1:0]           t_ptr;
    typedef logic [OCC_W-1:0]           t_occ;
    typedef logic [ID_WIDTH-1:0]        t_id;
    typedef logic signed [CNT_W-1:0]    t_count;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_WAIT   = 2'd0,
        CMD_SIGNAL = 2'd1,
        CMD_CLOSE  = 2'd2
    } t_cmd;

    // result codes
    typedef enum logic [KIND_W-1:0] {
        EV_DONE     = 2'd0,
        EV_BLOCKED  = 2'd1,
        EV_RELEASED = 2'd2,
        EV_FULL     = 2'd3
    } t_kind;

    // control from the sequencer to the waiter queue
    typedef struct packed {
        logic push;     // write id at tail
        logic pop;      // advance head
        logic clear;    // reset pointers and occupancy
        logic rd_en;    // read head entry into the output register
        logic rd_next;  // read the entry after head instead
    } t_q_ctl;

    // pointer increment with wrap at the queue depth
    function automatic t_ptr ptr_inc(input t_ptr p);
        if (p == t_ptr'(QUEUE_DEPTH - 1)) begin
            return '0;
        end else begin
            return p + t_ptr'(1);
        end
    endfunction

endpackage

// ----- rtl/core/csfw_queue.sv -----
module csfw_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  csfw_pkg::t_q_ctl i_ctl,
    input  csfw_pkg::t_id    i_push_id,
    output csfw_pkg::t_id    o_rd_id,
    output csfw_pkg::t_occ   o_occ
);
    import csfw_pkg::*;

    t_id  r_mem [QUEUE_DEPTH];
    t_id  r_rd_id;
    t_ptr r_head;
    t_ptr r_tail;
    t_occ r_occ;
    t_ptr head_nx;
    t_ptr rd_addr;

    assign head_nx = ptr_inc(r_head);
    assign rd_addr = i_ctl.rd_next ? head_nx : r_head;

    // waiter id storage, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_push_id;
        end
        if (i_ctl.rd_en) begin
            r_rd_id <= r_mem[rd_addr];
        end
    end

    // head, tail and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else begin
            if (i_ctl.push) begin
                r_tail <= ptr_inc(r_tail);
            end
            if (i_ctl.pop) begin
                r_head <= head_nx;
            end
            if (i_ctl.push && !i_ctl.pop) begin
                r_occ <= r_occ + t_occ'(1);
            end else if (i_ctl.pop && !i_ctl.push) begin
                r_occ <= r_occ - t_occ'(1);
            end
        end
    end

    assign o_rd_id = r_rd_id;
    assign o_occ   = r_occ;

endmodule

// ----- rtl/core/counting_semaphore_fifo_waitq_core.sv -----
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_stall     i_cmd, i_thread_id, i_caller_sleeping
// output    out        o_out_valid / i_out_stall   o_event_kind, o_released_id,
//                                                  o_count_now, o_last
// config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// wait, a signal that releases nothing and an unused command: answered in S_IDLE.
// signal that releases a waiter: goes through S_POP for the registered queue memory read.
// close: done in S_IDLE if empty; else S_DRAIN, one queue read per cycle unless stalled.
// synchronous reset clears count, pointers, occupancy and initial_count; no clearing pass.
// a stalled output holds the pending result; input is stalled until it can drain.
module counting_semaphore_fifo_waitq_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_thread_id,
    input  logic        i_caller_sleeping,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_released_id,
    output logic signed [15:0] o_count_now,
    output logic        o_last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import csfw_pkg::*;

    localparam logic REG_INITIAL_COUNT = 1'b0;
    localparam t_count CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
    localparam t_count CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_POP   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_count r_count, n_count;
    t_count r_init;
    logic   r_out_valid, n_out_valid;
    t_kind  r_out_kind, n_out_kind;
    logic [OUT_ID_W-1:0] r_out_id, n_out_id;
    t_count r_out_count, n_out_count;
    logic   r_out_last, n_out_last;

    t_q_ctl q_ctl;
    t_id    q_rd_id;
    t_occ   q_occ;
    t_id    in_id;
    logic   out_free;
    logic   in_accept;
    logic   load;
    logic   q_full;
    logic   q_one;
    t_count dec_count;
    t_count inc_count;

    csfw_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (q_ctl),
        .i_push_id (in_id),
        .o_rd_id   (q_rd_id),
        .o_occ     (q_occ)
    );

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INITIAL_COUNT) ? 32'(r_init) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_INITIAL_COUNT) begin
            r_init <= t_count'(pwdata[CNT_W-1:0]);
        end
    end

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !(r_state == S_IDLE && out_free);
    assign in_accept  = i_in_valid && r_state == S_IDLE && out_free;

    // saturating count steps and queue status
    assign in_id     = t_id'(i_thread_id);
    assign dec_count = (r_count == CNT_MIN) ? r_count : r_count - t_count'(1);
    assign inc_count = (r_count == CNT_MAX) ? r_count : r_count + t_count'(1);
    assign q_full    = q_occ == t_occ'(QUEUE_DEPTH);
    assign q_one     = q_occ == t_occ'(1);

    // command sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        q_ctl       = '0;
        load        = 1'b0;
        n_out_kind  = EV_DONE;
        n_out_id    = '0;
        n_out_count = r_count;
        n_out_last  = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (t_cmd'(i_cmd))
                        CMD_WAIT: begin
                            n_count     = dec_count;
                            n_out_count = dec_count;
                            load        = 1'b1;
                            if (dec_count[CNT_W-1] && !i_caller_sleeping) begin
                                n_out_id = OUT_ID_W'(in_id);
                                if (q_full) begin
                                    n_out_kind = EV_FULL;
                                end else begin
                                    n_out_kind = EV_BLOCKED;
                                    q_ctl.push = 1'b1;
                                end
                            end
                        end
                        CMD_SIGNAL: begin
                            n_count = inc_count;
                            if ((inc_count[CNT_W-1] || inc_count == '0) && q_occ != '0) begin
                                q_ctl.rd_en = 1'b1;
                                n_state     = S_POP;
                            end else begin
                                n_out_count = inc_count;
                                load        = 1'b1;
                            end
                        end
                        CMD_CLOSE: begin
                            if (q_occ == '0) begin
                                n_count     = r_init;
                                n_out_count = r_init;
                                load        = 1'b1;
                            end else begin
                                q_ctl.rd_en = 1'b1;
                                n_state     = S_DRAIN;
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    load       = 1'b1;
                    n_out_kind = EV_RELEASED;
                    n_out_id   = OUT_ID_W'(q_rd_id);
                    q_ctl.pop  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    load       = 1'b1;
                    n_out_kind = EV_RELEASED;
                    n_out_id   = OUT_ID_W'(q_rd_id);
                    n_out_last = q_one;
                    if (q_one) begin
                        n_count     = r_init;
                        n_out_count = r_init;
                        q_ctl.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        q_ctl.pop     = 1'b1;
                        q_ctl.rd_en   = 1'b1;
                        q_ctl.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = load || (r_out_valid && i_out_stall);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_kind  <= n_out_kind;
            r_out_id    <= n_out_id;
            r_out_count <= n_out_count;
            r_out_last  <= n_out_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_out_kind;
    assign o_released_id = r_out_id;
    assign o_count_now   = r_out_count;
    assign o_last        = r_out_last;

endmodule
